// ===== sv/fbbm_pkg.sv =====
`timescale 1ns / 1ps

package fbbm_pkg;

    // pool geometry, fixed by the 4-bit segment fields
    localparam int MAX_SEGS     = 16;
    localparam int INITIAL_SEGS = 3;
    localparam int SEG_W        = $clog2(MAX_SEGS);
    localparam int CNT_W        = $clog2(MAX_SEGS + 1);
    localparam int BORROW_W     = 8;
    localparam int RCV_W        = 8;
    localparam int TS_W         = 64;

    typedef logic [2:0]          t_action;
    typedef logic [1:0]          t_status;
    typedef logic [SEG_W-1:0]    t_seg;
    typedef logic [BORROW_W-1:0] t_borrow;
    typedef logic [TS_W-1:0]     t_ts;

    // action codes
    localparam t_action ACT_WRITE_START  = 3'd0;
    localparam t_action ACT_WRITE_END    = 3'd1;
    localparam t_action ACT_READ_START   = 3'd2;
    localparam t_action ACT_READ_END     = 3'd3;
    localparam t_action ACT_ADD_RECEIVER = 3'd4;
    localparam t_action ACT_CLOSE_SENDER = 3'd5;

    // status codes
    localparam t_status ST_OK            = 2'd0;
    localparam t_status ST_NO_RECEIVERS  = 2'd1;
    localparam t_status ST_SENDER_CLOSED = 2'd2;
    localparam t_status ST_POOL_FULL     = 2'd3;

    localparam t_borrow BORROW_MAX = {BORROW_W{1'b1}};

endpackage

// ===== sv/frame_buffer_borrow_manager_unit.sv =====
`timescale 1ns / 1ps

// timing: the result beat is registered in S_EXEC after the input beat is accepted,
//   later while the previous result is still waiting in the output register
// flow: a new item is taken only back in S_IDLE, after the read-modify-write of the
//   borrow count memory (read on accept, update and write back in S_EXEC)
// reset: state registers return to initial values, beat and result data are not
//   reset; borrow count and timestamp memories read zero via per-entry valid bits, no clearing pass
module frame_buffer_borrow_manager_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  fbbm_pkg::t_action     i_action,
    input  logic [3:0]            i_segment_index,
    input  fbbm_pkg::t_ts         i_timestamp_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output fbbm_pkg::t_status     o_status,
    output logic [3:0]            o_segment,
    output fbbm_pkg::t_ts         o_timestamp_out
);
    import fbbm_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // control state
    t_state               r_state, n_state;
    t_action              r_action, n_action;
    t_ts                  r_ts_in, n_ts_in;
    t_seg                 r_addr, n_addr;
    t_seg                 r_newest, n_newest;
    t_seg                 r_older, n_older;
    t_seg                 r_pending, n_pending;
    logic [CNT_W-1:0]     r_seg_count, n_seg_count;
    logic [RCV_W-1:0]     r_rcv_count, n_rcv_count;
    logic                 r_conflate, n_conflate;
    logic                 r_closed, n_closed;
    logic [MAX_SEGS-1:0]  r_busy, n_busy;
    logic [MAX_SEGS-1:0]  r_bc_vld, n_bc_vld;
    logic [MAX_SEGS-1:0]  r_ts_vld, n_ts_vld;
    logic                 r_bc_q_vld, r_ts_q_vld;
    logic                 r_out_valid, n_out_valid;
    t_status              r_status, n_status;
    t_seg                 r_segment, n_segment;
    t_ts                  r_ts_out, n_ts_out;

    // memories
    t_borrow              r_bc_mem [MAX_SEGS];
    t_ts                  r_ts_mem [MAX_SEGS];
    t_borrow              r_bc_q;
    t_ts                  r_ts_q;
    logic                 bc_we, ts_we;
    t_seg                 ts_waddr;
    t_borrow              bc_wdata;

    logic                 in_fire;
    logic                 out_free;
    t_borrow              cnt;
    t_seg                 pick;
    logic                 found;

    assign o_in_ready      = (r_state == S_IDLE);
    assign in_fire         = i_in_valid & o_in_ready;
    assign out_free        = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_segment       = r_segment;
    assign o_timestamp_out = r_ts_out;

    // borrow count as read, unwritten entries read as zero
    assign cnt = r_bc_q_vld ? r_bc_q : '0;

    // lowest free segment below the pool size, other than the newest
    always_comb begin
        found = 1'b0;
        pick  = r_newest;
        for (int i = 0; i < MAX_SEGS; i++) begin
            if (!found && (CNT_W'(i) < r_seg_count) && (SEG_W'(i) != r_newest)
                    && !r_busy[i]) begin
                found = 1'b1;
                pick  = SEG_W'(i);
            end
        end
    end

    // next state and result
    always_comb begin
        n_state     = r_state;
        n_action    = r_action;
        n_ts_in     = r_ts_in;
        n_addr      = r_addr;
        n_newest    = r_newest;
        n_older     = r_older;
        n_pending   = r_pending;
        n_seg_count = r_seg_count;
        n_rcv_count = r_rcv_count;
        n_conflate  = r_conflate;
        n_closed    = r_closed;
        n_busy      = r_busy;
        n_bc_vld    = r_bc_vld;
        n_ts_vld    = r_ts_vld;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_segment   = r_segment;
        n_ts_out    = r_ts_out;
        bc_we       = 1'b0;
        bc_wdata    = cnt;
        ts_we       = 1'b0;
        ts_waddr    = r_pending;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                // capture the beat, memory read address goes out with it
                if (in_fire) begin
                    n_action = i_action;
                    n_ts_in  = i_timestamp_in;
                    if (i_action == ACT_READ_START) begin
                        n_addr = r_conflate ? r_newest : r_older;
                    end else begin
                        n_addr = SEG_W'(i_segment_index);
                    end
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                // update and write back only when the result register is free
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_segment   = '0;
                    n_ts_out    = '0;
                    n_state     = S_IDLE;
                    case (r_action)
                        ACT_WRITE_START: begin
                            if (r_rcv_count == '0) begin
                                n_status = ST_NO_RECEIVERS;
                            end else begin
                                if (found) begin
                                    n_older = r_newest;
                                end else begin
                                    n_conflate = 1'b1;
                                end
                                n_pending = pick;
                                n_segment = pick;
                            end
                        end
                        ACT_WRITE_END: begin
                            ts_we              = 1'b1;
                            ts_waddr           = r_pending;
                            n_ts_vld[r_pending] = 1'b1;
                            n_newest           = r_pending;
                            n_conflate         = 1'b0;
                        end
                        ACT_READ_START: begin
                            if (r_closed) begin
                                n_status = ST_SENDER_CLOSED;
                            end else begin
                                if (cnt != BORROW_MAX) begin
                                    bc_we    = 1'b1;
                                    bc_wdata = cnt + 1'b1;
                                end
                                n_bc_vld[r_addr] = 1'b1;
                                n_busy[r_addr]   = 1'b1;
                                n_segment        = r_addr;
                                n_ts_out         = r_ts_q_vld ? r_ts_q : '0;
                            end
                        end
                        ACT_READ_END: begin
                            if (cnt != '0) begin
                                bc_we            = 1'b1;
                                bc_wdata         = cnt - 1'b1;
                                n_bc_vld[r_addr] = 1'b1;
                                n_busy[r_addr]   = (cnt != t_borrow'(1));
                            end
                        end
                        ACT_ADD_RECEIVER: begin
                            if (r_seg_count >= CNT_W'(MAX_SEGS)) begin
                                n_status = ST_POOL_FULL;
                            end else begin
                                n_seg_count = r_seg_count + 1'b1;
                                n_rcv_count = r_rcv_count + 1'b1;
                            end
                        end
                        ACT_CLOSE_SENDER: begin
                            n_closed = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_newest    <= '0;
            r_older     <= SEG_W'(1);
            r_pending   <= '0;
            r_seg_count <= CNT_W'(INITIAL_SEGS);
            r_rcv_count <= RCV_W'(1);
            r_conflate  <= 1'b0;
            r_closed    <= 1'b0;
            r_busy      <= '0;
            r_bc_vld    <= '0;
            r_ts_vld    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_newest    <= n_newest;
            r_older     <= n_older;
            r_pending   <= n_pending;
            r_seg_count <= n_seg_count;
            r_rcv_count <= n_rcv_count;
            r_conflate  <= n_conflate;
            r_closed    <= n_closed;
            r_busy      <= n_busy;
            r_bc_vld    <= n_bc_vld;
            r_ts_vld    <= n_ts_vld;
            r_out_valid <= n_out_valid;
        end
        r_action  <= n_action;
        r_ts_in   <= n_ts_in;
        r_addr    <= n_addr;
        r_status  <= n_status;
        r_segment <= n_segment;
        r_ts_out  <= n_ts_out;
    end

    // borrow count memory, read on accept, written back in the update cycle
    always_ff @(posedge i_clk) begin
        if (bc_we) begin
            r_bc_mem[r_addr] <= bc_wdata;
        end
        r_bc_q     <= r_bc_mem[n_addr];
        r_bc_q_vld <= r_bc_vld[n_addr];
    end

    // timestamp memory
    always_ff @(posedge i_clk) begin
        if (ts_we) begin
            r_ts_mem[ts_waddr] <= r_ts_in;
        end
        r_ts_q     <= r_ts_mem[n_addr];
        r_ts_q_vld <= r_ts_vld[n_addr];
    end

endmodule
